// File: src/bps_pkg.sv
package bps_pkg;

    localparam int STORE_DEPTH_DEF   = 65536;
    localparam int MAX_DIMENSION_DEF = 1024;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int CFG_DIM_W  = 11;
    localparam int CFG_COMP_W = 3;
    localparam int INDEX_W    = 16;
    localparam int PIXEL_W    = 32;
    localparam int COORD_W    = 20;
    localparam int VALUE_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int CHANNELS   = 4;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COMPS  = 2'd2;

    localparam logic [CFG_COMP_W-1:0] COMPS_MAX = 3'd4;

    typedef struct packed {
        logic valid;
        logic sample;
        logic write;
    } stage_ctl_t;

endpackage

// File: src/bps_config.sv
module bps_config #(
    parameter int MAX_DIMENSION = bps_pkg::MAX_DIMENSION_DEF,
    parameter int DIM_W         = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bps_pkg::APB_DATA_W-1:0]    prdata,
    output logic [DIM_W-1:0]                  width_sat,
    output logic [DIM_W-1:0]                  height_sat,
    output logic [bps_pkg::CFG_COMP_W-1:0]    comp_count,
    output logic [2*DIM_W-1:0]                area
);

    localparam int SW = (DIM_W > bps_pkg::CFG_DIM_W) ? DIM_W : bps_pkg::CFG_DIM_W;

    logic [bps_pkg::CFG_DIM_W-1:0]  width_reg;
    logic [bps_pkg::CFG_DIM_W-1:0]  height_reg;
    logic [bps_pkg::CFG_COMP_W-1:0] comps_reg;
    logic [2*DIM_W-1:0]             area_reg;
    logic                           wr_hit;
    logic [1:0]                     reg_sel;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [bps_pkg::CFG_DIM_W-1:0] v);
        logic [SW-1:0] wide;
        wide = SW'(v);
        if (wide == '0)
            sat_dim = DIM_W'(1);
        else if (wide > SW'(MAX_DIMENSION))
            sat_dim = DIM_W'(MAX_DIMENSION);
        else
            sat_dim = DIM_W'(wide);
    endfunction

    assign wr_hit  = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bps_pkg::CFG_DIM_W'(1);
            height_reg <= bps_pkg::CFG_DIM_W'(1);
            comps_reg  <= bps_pkg::COMPS_MAX;
        end
        else if (wr_hit)
        begin
            case (reg_sel)
                bps_pkg::REG_WIDTH:  width_reg  <= pwdata[bps_pkg::CFG_DIM_W-1:0];
                bps_pkg::REG_HEIGHT: height_reg <= pwdata[bps_pkg::CFG_DIM_W-1:0];
                bps_pkg::REG_COMPS:  comps_reg  <= pwdata[bps_pkg::CFG_COMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            bps_pkg::REG_WIDTH:  prdata = bps_pkg::APB_DATA_W'(width_reg);
            bps_pkg::REG_HEIGHT: prdata = bps_pkg::APB_DATA_W'(height_reg);
            bps_pkg::REG_COMPS:  prdata = bps_pkg::APB_DATA_W'(comps_reg);
            default:             prdata = '0;
        endcase
    end

    assign width_sat  = sat_dim(width_reg);
    assign height_sat = sat_dim(height_reg);

    always_comb
    begin
        if (comps_reg == '0)
            comp_count = bps_pkg::CFG_COMP_W'(1);
        else if (comps_reg > bps_pkg::COMPS_MAX)
            comp_count = bps_pkg::COMPS_MAX;
        else
            comp_count = comps_reg;
    end

    always_ff @(posedge clk)
    begin
        area_reg <= (2*DIM_W)'(width_sat) * (2*DIM_W)'(height_sat);
    end

    assign area = area_reg;

endmodule

// File: src/bps_addr.sv
module bps_addr #(
    parameter int STORE_DEPTH   = bps_pkg::STORE_DEPTH_DEF,
    parameter int STORE_AW      = 16,
    parameter int DIM_W         = 11,
    parameter int FRACTION_BITS = bps_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  item_valid,
    input  logic                                  operation,
    input  logic [bps_pkg::INDEX_W-1:0]           pixel_index,
    input  logic [bps_pkg::PIXEL_W-1:0]           pixel_data,
    input  logic signed [bps_pkg::COORD_W-1:0]    sample_x,
    input  logic signed [bps_pkg::COORD_W-1:0]    sample_y,
    input  logic [DIM_W-1:0]                      width_sat,
    input  logic [DIM_W-1:0]                      height_sat,
    input  logic [2*DIM_W-1:0]                    area,
    output bps_pkg::stage_ctl_t                   ctl,
    output logic [STORE_AW-1:0]                   wr_addr,
    output logic [bps_pkg::PIXEL_W-1:0]           wr_data,
    output logic [STORE_AW-1:0]                   addr00,
    output logic [STORE_AW-1:0]                   addr01,
    output logic [STORE_AW-1:0]                   addr10,
    output logic [STORE_AW-1:0]                   addr11,
    output logic [FRACTION_BITS-1:0]              fx,
    output logic [FRACTION_BITS-1:0]              fy
);

    localparam int XW = DIM_W + FRACTION_BITS;
    localparam int CW = (XW + 1 > bps_pkg::COORD_W) ? XW + 1 : bps_pkg::COORD_W;
    localparam int RW = 2 * DIM_W;

    function automatic logic [XW-1:0] clamp_coord(
        input logic signed [bps_pkg::COORD_W-1:0] c,
        input logic [DIM_W-1:0]                   dim
    );
        logic signed [CW-1:0] cw;
        logic signed [CW-1:0] hi;
        cw = CW'(c);
        hi = signed'(CW'({dim - DIM_W'(1), {FRACTION_BITS{1'b0}}}));
        if (cw[CW-1])
            clamp_coord = '0;
        else if (cw > hi)
            clamp_coord = hi[XW-1:0];
        else
            clamp_coord = cw[XW-1:0];
    endfunction

    function automatic logic [STORE_AW-1:0] wrap_row(input logic [RW-1:0] a);
        logic [RW+STORE_AW-1:0] ext;
        ext = (RW+STORE_AW)'(a);
        wrap_row = ext[STORE_AW-1:0];
    endfunction

    function automatic logic [STORE_AW-1:0] wrap_index(input logic [bps_pkg::INDEX_W-1:0] a);
        logic [bps_pkg::INDEX_W+STORE_AW-1:0] ext;
        ext = (bps_pkg::INDEX_W+STORE_AW)'(a);
        wrap_index = ext[STORE_AW-1:0];
    endfunction

    // stage 1: clamp
    logic [XW-1:0]                  x_clamp;
    logic [XW-1:0]                  y_clamp;
    logic                           s1_valid_reg;
    logic                           s1_sample_reg;
    logic [bps_pkg::INDEX_W-1:0]    s1_index_reg;
    logic [bps_pkg::PIXEL_W-1:0]    s1_data_reg;
    logic [DIM_W-1:0]               s1_ix_reg;
    logic [DIM_W-1:0]               s1_iy_reg;
    logic [FRACTION_BITS-1:0]       s1_fx_reg;
    logic [FRACTION_BITS-1:0]       s1_fy_reg;

    assign x_clamp = clamp_coord(sample_x, width_sat);
    assign y_clamp = clamp_coord(sample_y, height_sat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sample_reg <= (operation == bps_pkg::OP_SAMPLE);
            s1_index_reg  <= pixel_index;
            s1_data_reg   <= pixel_data;
            s1_ix_reg     <= x_clamp[FRACTION_BITS +: DIM_W];
            s1_iy_reg     <= y_clamp[FRACTION_BITS +: DIM_W];
            s1_fx_reg     <= x_clamp[FRACTION_BITS-1:0];
            s1_fy_reg     <= y_clamp[FRACTION_BITS-1:0];
        end
    end

    // stage 2: neighbors, row base, write check
    logic [DIM_W:0]                 ix_inc;
    logic [DIM_W:0]                 iy_inc;
    logic [DIM_W-1:0]               ix2;
    logic                           wr_ok;
    logic                           s2_valid_reg;
    logic                           s2_sample_reg;
    logic                           s2_write_reg;
    logic [RW-1:0]                  s2_row_reg;
    logic [DIM_W-1:0]               s2_ix_reg;
    logic [DIM_W-1:0]               s2_ix2_reg;
    logic                           s2_step_y_reg;
    logic [FRACTION_BITS-1:0]       s2_fx_reg;
    logic [FRACTION_BITS-1:0]       s2_fy_reg;
    logic [bps_pkg::INDEX_W-1:0]    s2_index_reg;
    logic [bps_pkg::PIXEL_W-1:0]    s2_data_reg;

    assign ix_inc = {1'b0, s1_ix_reg} + (DIM_W+1)'(1);
    assign iy_inc = {1'b0, s1_iy_reg} + (DIM_W+1)'(1);
    assign ix2    = (ix_inc < {1'b0, width_sat}) ? ix_inc[DIM_W-1:0] : width_sat - DIM_W'(1);
    assign wr_ok  = !s1_sample_reg
                  && (32'(s1_index_reg) < 32'(area))
                  && (32'(s1_index_reg) < 32'(STORE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_write_reg  <= wr_ok;
            s2_row_reg    <= RW'(s1_iy_reg) * RW'(width_sat);
            s2_ix_reg     <= s1_ix_reg;
            s2_ix2_reg    <= ix2;
            s2_step_y_reg <= (iy_inc < {1'b0, height_sat});
            s2_fx_reg     <= s1_fx_reg;
            s2_fy_reg     <= s1_fy_reg;
            s2_index_reg  <= s1_index_reg;
            s2_data_reg   <= s1_data_reg;
        end
    end

    // stage 3: store addresses
    logic [RW-1:0]                  row_b;
    bps_pkg::stage_ctl_t            s3_ctl_reg;
    logic [STORE_AW-1:0]            s3_wr_addr_reg;
    logic [bps_pkg::PIXEL_W-1:0]    s3_wr_data_reg;
    logic [STORE_AW-1:0]            s3_addr00_reg;
    logic [STORE_AW-1:0]            s3_addr01_reg;
    logic [STORE_AW-1:0]            s3_addr10_reg;
    logic [STORE_AW-1:0]            s3_addr11_reg;
    logic [FRACTION_BITS-1:0]       s3_fx_reg;
    logic [FRACTION_BITS-1:0]       s3_fy_reg;

    assign row_b = s2_row_reg + (s2_step_y_reg ? RW'(width_sat) : RW'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_ctl_reg <= '0;
        else if (adv)
        begin
            s3_ctl_reg.valid  <= s2_valid_reg;
            s3_ctl_reg.sample <= s2_valid_reg && s2_sample_reg;
            s3_ctl_reg.write  <= s2_valid_reg && s2_write_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_wr_addr_reg <= wrap_index(s2_index_reg);
            s3_wr_data_reg <= s2_data_reg;
            s3_addr00_reg  <= wrap_row(s2_row_reg + RW'(s2_ix_reg));
            s3_addr10_reg  <= wrap_row(s2_row_reg + RW'(s2_ix2_reg));
            s3_addr01_reg  <= wrap_row(row_b + RW'(s2_ix_reg));
            s3_addr11_reg  <= wrap_row(row_b + RW'(s2_ix2_reg));
            s3_fx_reg      <= s2_fx_reg;
            s3_fy_reg      <= s2_fy_reg;
        end
    end

    assign ctl     = s3_ctl_reg;
    assign wr_addr = s3_wr_addr_reg;
    assign wr_data = s3_wr_data_reg;
    assign addr00  = s3_addr00_reg;
    assign addr01  = s3_addr01_reg;
    assign addr10  = s3_addr10_reg;
    assign addr11  = s3_addr11_reg;
    assign fx      = s3_fx_reg;
    assign fy      = s3_fy_reg;

    a_write_not_sample: assert property (@(posedge clk) disable iff (!rst_n)
        s3_ctl_reg.write |-> (s3_ctl_reg.valid && !s3_ctl_reg.sample))
        else $error("write beat flagged as sample");

    a_right_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_sample_reg)
        |-> ({1'b0, s2_ix2_reg} <= ({1'b0, s2_ix_reg} + (DIM_W+1)'(1))))
        else $error("right neighbor beyond next column");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv) |=> s2_valid_reg)
        else $error("beat lost between clamp and row stage");

endmodule

// File: src/bps_store.sv
module bps_store #(
    parameter int STORE_DEPTH = bps_pkg::STORE_DEPTH_DEF,
    parameter int STORE_AW    = 16
) (
    input  logic                          clk,
    input  logic                          adv,
    input  bps_pkg::stage_ctl_t           ctl,
    input  logic [STORE_AW-1:0]           wr_addr,
    input  logic [bps_pkg::PIXEL_W-1:0]   wr_data,
    input  logic [STORE_AW-1:0]           addr00,
    input  logic [STORE_AW-1:0]           addr01,
    input  logic [STORE_AW-1:0]           addr10,
    input  logic [STORE_AW-1:0]           addr11,
    output logic [bps_pkg::PIXEL_W-1:0]   pix00,
    output logic [bps_pkg::PIXEL_W-1:0]   pix01,
    output logic [bps_pkg::PIXEL_W-1:0]   pix10,
    output logic [bps_pkg::PIXEL_W-1:0]   pix11
);

    // two copies: upper row pair and lower row pair, two read ports each
    logic [bps_pkg::PIXEL_W-1:0] upper_mem [STORE_DEPTH];
    logic [bps_pkg::PIXEL_W-1:0] lower_mem [STORE_DEPTH];

    logic [bps_pkg::PIXEL_W-1:0] pix00_reg;
    logic [bps_pkg::PIXEL_W-1:0] pix01_reg;
    logic [bps_pkg::PIXEL_W-1:0] pix10_reg;
    logic [bps_pkg::PIXEL_W-1:0] pix11_reg;

    always_ff @(posedge clk)
    begin
        if (adv && ctl.write)
        begin
            upper_mem[wr_addr] <= wr_data;
            lower_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl.sample)
        begin
            pix00_reg <= upper_mem[addr00];
            pix10_reg <= upper_mem[addr10];
            pix01_reg <= lower_mem[addr01];
            pix11_reg <= lower_mem[addr11];
        end
    end

    assign pix00 = pix00_reg;
    assign pix01 = pix01_reg;
    assign pix10 = pix10_reg;
    assign pix11 = pix11_reg;

endmodule

// File: src/bps_blend.sv
module bps_blend #(
    parameter int FRACTION_BITS = bps_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  bps_pkg::stage_ctl_t               ctl,
    input  logic [FRACTION_BITS-1:0]          fx,
    input  logic [FRACTION_BITS-1:0]          fy,
    input  logic [bps_pkg::PIXEL_W-1:0]       pix00,
    input  logic [bps_pkg::PIXEL_W-1:0]       pix01,
    input  logic [bps_pkg::PIXEL_W-1:0]       pix10,
    input  logic [bps_pkg::PIXEL_W-1:0]       pix11,
    input  logic [bps_pkg::CFG_COMP_W-1:0]    comp_count,
    output logic                              result_valid,
    output logic [bps_pkg::VALUE_W-1:0]       value_c0,
    output logic [bps_pkg::VALUE_W-1:0]       value_c1,
    output logic [bps_pkg::VALUE_W-1:0]       value_c2,
    output logic [bps_pkg::VALUE_W-1:0]       value_c3
);

    localparam int WW = FRACTION_BITS + 1;
    localparam int AW = bps_pkg::CHAN_W + FRACTION_BITS;
    localparam int PW = bps_pkg::CHAN_W + WW;
    localparam int TW = bps_pkg::CHAN_W + 2 * FRACTION_BITS;
    localparam logic [WW-1:0] SCALE = WW'(1) << FRACTION_BITS;

    // stage 4: fractions alongside the store read
    logic                       s4_valid_reg;
    logic [FRACTION_BITS-1:0]   s4_fx_reg;
    logic [FRACTION_BITS-1:0]   s4_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= ctl.valid && ctl.sample;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_fx_reg <= fx;
            s4_fy_reg <= fy;
        end
    end

    // stage 5: vertical blend
    logic [WW-1:0]  wy0;
    logic [WW-1:0]  wy1;
    logic [AW-1:0]  lerp_a [bps_pkg::CHANNELS];
    logic [AW-1:0]  lerp_b [bps_pkg::CHANNELS];
    logic           s5_valid_reg;
    logic [FRACTION_BITS-1:0] s5_fx_reg;
    logic [AW-1:0]  s5_a_reg [bps_pkg::CHANNELS];
    logic [AW-1:0]  s5_b_reg [bps_pkg::CHANNELS];

    assign wy1 = WW'(s4_fy_reg);
    assign wy0 = SCALE - wy1;

    always_comb
    begin
        logic [PW-1:0] sum_a;
        logic [PW-1:0] sum_b;
        for (int k = 0; k < bps_pkg::CHANNELS; k++)
        begin
            sum_a = PW'(pix00[bps_pkg::CHAN_W*k +: bps_pkg::CHAN_W]) * PW'(wy0)
                  + PW'(pix01[bps_pkg::CHAN_W*k +: bps_pkg::CHAN_W]) * PW'(wy1);
            sum_b = PW'(pix10[bps_pkg::CHAN_W*k +: bps_pkg::CHAN_W]) * PW'(wy0)
                  + PW'(pix11[bps_pkg::CHAN_W*k +: bps_pkg::CHAN_W]) * PW'(wy1);
            lerp_a[k] = sum_a[AW-1:0];
            lerp_b[k] = sum_b[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_fx_reg <= s4_fx_reg;
            for (int k = 0; k < bps_pkg::CHANNELS; k++)
            begin
                s5_a_reg[k] <= lerp_a[k];
                s5_b_reg[k] <= lerp_b[k];
            end
        end
    end

    // stage 6: horizontal blend into the output register
    logic [WW-1:0]               wx0;
    logic [WW-1:0]               wx1;
    logic [bps_pkg::VALUE_W-1:0] value_next [bps_pkg::CHANNELS];
    logic                        result_valid_reg;
    logic [bps_pkg::VALUE_W-1:0] value_reg [bps_pkg::CHANNELS];

    assign wx1 = WW'(s5_fx_reg);
    assign wx0 = SCALE - wx1;

    always_comb
    begin
        logic [TW-1:0] total;
        for (int k = 0; k < bps_pkg::CHANNELS; k++)
        begin
            total = TW'(s5_a_reg[k]) * TW'(wx0) + TW'(s5_b_reg[k]) * TW'(wx1);
            if (bps_pkg::CFG_COMP_W'(k) < comp_count)
                value_next[k] = total[TW-1 -: bps_pkg::VALUE_W];
            else
                value_next[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < bps_pkg::CHANNELS; k++)
                value_reg[k] <= value_next[k];
        end
    end

    assign result_valid = result_valid_reg;
    assign value_c0     = value_reg[0];
    assign value_c1     = value_reg[1];
    assign value_c2     = value_reg[2];
    assign value_c3     = value_reg[3];

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (value_reg[0] <= 16'hFF00) && (value_reg[1] <= 16'hFF00)
                          && (value_reg[2] <= 16'hFF00) && (value_reg[3] <= 16'hFF00))
        else $error("blended value above full scale");

    a_vert_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && adv) |=> s5_valid_reg)
        else $error("sample lost after store read");

    a_horiz_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && adv) |=> result_valid_reg)
        else $error("sample lost before output register");

endmodule

// File: src/bilinear_pixel_sampler.sv
// channel   | handshake                   | payload
// ----------+-----------------------------+--------------------------------------------
// item      | item_valid / item_ready     | operation, pixel_index, pixel_data,
//           |                             | sample_x, sample_y
// result    | result_valid / result_ready | value_c0, value_c1, value_c2, value_c3
// config    | psel, penable, pwrite       | paddr, pwdata, prdata, pready
//
// One item per cycle unless a stalled result holds the pipeline; a sample beat gives one
// result, a write beat gives none. The two dual-read copies of the pixel store feed all
// four neighbors in the same cycle, so the store read stage sets the rate.
// Reset clears the valid bits and the width, height and comps registers, not the store.
// A stalled result freezes every stage together; item_ready drops in the same cycle.
module bilinear_pixel_sampler #(
    parameter int STORE_DEPTH   = bps_pkg::STORE_DEPTH_DEF,
    parameter int MAX_DIMENSION = bps_pkg::MAX_DIMENSION_DEF,
    parameter int FRACTION_BITS = bps_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  operation,
    input  logic [bps_pkg::INDEX_W-1:0]           pixel_index,
    input  logic [bps_pkg::PIXEL_W-1:0]           pixel_data,
    input  logic signed [bps_pkg::COORD_W-1:0]    sample_x,
    input  logic signed [bps_pkg::COORD_W-1:0]    sample_y,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [bps_pkg::VALUE_W-1:0]           value_c0,
    output logic [bps_pkg::VALUE_W-1:0]           value_c1,
    output logic [bps_pkg::VALUE_W-1:0]           value_c2,
    output logic [bps_pkg::VALUE_W-1:0]           value_c3,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bps_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [bps_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [bps_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int STORE_AW = $clog2(STORE_DEPTH);
    localparam int DIM_W    = $clog2(MAX_DIMENSION + 1);

    logic                           adv;
    logic [DIM_W-1:0]               width_sat;
    logic [DIM_W-1:0]               height_sat;
    logic [bps_pkg::CFG_COMP_W-1:0] comp_count;
    logic [2*DIM_W-1:0]             area;
    bps_pkg::stage_ctl_t            s3_ctl;
    logic [STORE_AW-1:0]            wr_addr;
    logic [bps_pkg::PIXEL_W-1:0]    wr_data;
    logic [STORE_AW-1:0]            addr00;
    logic [STORE_AW-1:0]            addr01;
    logic [STORE_AW-1:0]            addr10;
    logic [STORE_AW-1:0]            addr11;
    logic [FRACTION_BITS-1:0]       fx;
    logic [FRACTION_BITS-1:0]       fy;
    logic [bps_pkg::PIXEL_W-1:0]    pix00;
    logic [bps_pkg::PIXEL_W-1:0]    pix01;
    logic [bps_pkg::PIXEL_W-1:0]    pix10;
    logic [bps_pkg::PIXEL_W-1:0]    pix11;

    assign adv        = !result_valid || result_ready;
    assign item_ready = adv;
    assign pready     = 1'b1;

    bps_config #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .DIM_W         (DIM_W)
    ) u_config (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .width_sat  (width_sat),
        .height_sat (height_sat),
        .comp_count (comp_count),
        .area       (area)
    );

    bps_addr #(
        .STORE_DEPTH   (STORE_DEPTH),
        .STORE_AW      (STORE_AW),
        .DIM_W         (DIM_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item_valid  (item_valid),
        .operation   (operation),
        .pixel_index (pixel_index),
        .pixel_data  (pixel_data),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .width_sat   (width_sat),
        .height_sat  (height_sat),
        .area        (area),
        .ctl         (s3_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .addr00      (addr00),
        .addr01      (addr01),
        .addr10      (addr10),
        .addr11      (addr11),
        .fx          (fx),
        .fy          (fy)
    );

    bps_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .STORE_AW    (STORE_AW)
    ) u_store (
        .clk     (clk),
        .adv     (adv),
        .ctl     (s3_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .addr00  (addr00),
        .addr01  (addr01),
        .addr10  (addr10),
        .addr11  (addr11),
        .pix00   (pix00),
        .pix01   (pix01),
        .pix10   (pix10),
        .pix11   (pix11)
    );

    bps_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .ctl          (s3_ctl),
        .fx           (fx),
        .fy           (fy),
        .pix00        (pix00),
        .pix01        (pix01),
        .pix10        (pix10),
        .pix11        (pix11),
        .comp_count   (comp_count),
        .result_valid (result_valid),
        .value_c0     (value_c0),
        .value_c1     (value_c1),
        .value_c2     (value_c2),
        .value_c3     (value_c3)
    );

endmodule

// File: test/bilinear_pixel_sampler_test.sv
module bilinear_pixel_sampler_test;

    import bps_pkg::*;

    localparam int TIMEOUT      = 2_000_000;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int CORNERS      = 4;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef logic [CHANNELS-1:0][VALUE_W-1:0] value_set_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 op;
        logic [INDEX_W-1:0]   idx;
        logic [PIXEL_W-1:0]   data;
        logic [COORD_W-1:0]   sx;
        logic [COORD_W-1:0]   sy;
        logic                 known;
        value_set_t           want;
    } step_row_t;

    typedef struct packed {
        logic [CORNERS-1:0][INDEX_W-1:0] addr;
        logic [15:0]                     fx;
        logic [15:0]                     fy;
    } footprint_t;

    localparam int PLAN_LEN = 29;
    localparam step_row_t PLAN [PLAN_LEN] = '{
        '{ROW_ITEM, OP_WRITE,  16'h0, 32'hFFFF_FFFF, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h0, 20'h0, 1'b1, 64'hFF00_FF00_FF00_FF00},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h7FFFF, 20'h7FFFF, 1'b1,
          64'hFF00_FF00_FF00_FF00},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h80000, 20'h80000, 1'b1,
          64'hFF00_FF00_FF00_FF00},
        '{ROW_ITEM, OP_WRITE,  16'h1, 32'h0, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h0, 20'h0, 1'b1, 64'hFF00_FF00_FF00_FF00},
        '{ROW_ITEM, OP_WRITE,  16'hFFFF, 32'h0, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h100, 20'h080, 1'b1,
          64'hFF00_FF00_FF00_FF00},
        '{ROW_ITEM, OP_WRITE,  16'h0, 32'h1234_5678, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h0, 20'h0, 1'b1, 64'h1200_3400_5600_7800},
        '{ROW_CFG,  OP_WRITE,  16'(REG_WIDTH),  32'd2, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_CFG,  OP_WRITE,  16'(REG_HEIGHT), 32'd2, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_WRITE,  16'h0, 32'hFF00_FF00, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_WRITE,  16'h1, 32'h00FF_00FF, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_WRITE,  16'h2, 32'h8080_8080, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_WRITE,  16'h3, 32'h0102_0304, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h080, 20'h080, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h0FF, 20'h001, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h100, 20'h100, 1'b1,
          64'h0100_0200_0300_0400},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h7FFFF, 20'h80000, 1'b1,
          64'h0000_FF00_0000_FF00},
        '{ROW_CFG,  OP_WRITE,  16'(REG_COMPS), 32'd1, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h100, 20'h100, 1'b1,
          64'h0000_0000_0000_0400},
        '{ROW_CFG,  OP_WRITE,  16'(REG_COMPS), 32'd0, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h100, 20'h100, 1'b1,
          64'h0000_0000_0000_0400},
        '{ROW_CFG,  OP_WRITE,  16'(REG_COMPS), 32'd7, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_CFG,  OP_WRITE,  16'(REG_WIDTH), 32'd0, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h100, 20'h100, 1'b1,
          64'h0000_FF00_0000_FF00},
        '{ROW_CFG,  OP_WRITE,  16'(REG_SPARE), 32'hFFFF_FFFF, 20'h0, 20'h0, 1'b0, 64'h0},
        '{ROW_ITEM, OP_SAMPLE, 16'h0, 32'h0, 20'h100, 20'h080, 1'b0, 64'h0}
    };

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    logic                   operation    = OP_WRITE;
    logic [INDEX_W-1:0]     pixel_index  = '0;
    logic [PIXEL_W-1:0]     pixel_data   = '0;
    logic [COORD_W-1:0]     sample_x     = '0;
    logic [COORD_W-1:0]     sample_y     = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [VALUE_W-1:0]     value_c0;
    logic [VALUE_W-1:0]     value_c1;
    logic [VALUE_W-1:0]     value_c2;
    logic [VALUE_W-1:0]     value_c3;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr        = '0;
    logic [APB_DATA_W-1:0]  pwdata       = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    logic [PIXEL_W-1:0]     pixel_mem [STORE_DEPTH_DEF];
    bit                     pixel_written [STORE_DEPTH_DEF];
    logic [CFG_DIM_W-1:0]   cfg_width  = 1;
    logic [CFG_DIM_W-1:0]   cfg_height = 1;
    logic [CFG_COMP_W-1:0]  cfg_comps  = COMPS_MAX;

    value_set_t             predicted_values [$];
    int                     mismatches  = 0;
    int unsigned            items_sent  = 0;
    int                     idle_pct    = 0;
    int                     stall_pct   = 0;
    int                     hold_asked  = 0;
    int                     hold_seen   = 0;
    int                     hold_left   = 0;

    bilinear_pixel_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .pixel_index  (pixel_index),
        .pixel_data   (pixel_data),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value_c0     (value_c0),
        .value_c1     (value_c1),
        .value_c2     (value_c2),
        .value_c3     (value_c3),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_dim(logic [CFG_DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIMENSION_DEF)
            return MAX_DIMENSION_DEF;
        return v;
    endfunction

    function automatic int unsigned image_area();
        return eff_dim(cfg_width) * eff_dim(cfg_height);
    endfunction

    function automatic logic [INDEX_W-1:0] pixel_addr(int unsigned row, int unsigned col,
                                                      int unsigned w);
        return INDEX_W'((row * w + col) % STORE_DEPTH_DEF);
    endfunction

    function automatic footprint_t footprint(logic signed [COORD_W-1:0] sx,
                                             logic signed [COORD_W-1:0] sy);
        int unsigned w, h, ix, iy, ix2, iy2;
        int x, y, xmax, ymax;
        footprint_t fp;
        w = eff_dim(cfg_width);
        h = eff_dim(cfg_height);
        xmax = int'(w - 1) << FRACTION_BITS_DEF;
        ymax = int'(h - 1) << FRACTION_BITS_DEF;
        x = sx;
        y = sy;
        x = (x < 0) ? 0 : ((x > xmax) ? xmax : x);
        y = (y < 0) ? 0 : ((y > ymax) ? ymax : y);
        ix = x >> FRACTION_BITS_DEF;
        iy = y >> FRACTION_BITS_DEF;
        fp.fx = 16'(x & ((1 << FRACTION_BITS_DEF) - 1));
        fp.fy = 16'(y & ((1 << FRACTION_BITS_DEF) - 1));
        ix2 = (ix + 1 < w) ? ix + 1 : w - 1;
        iy2 = (iy + 1 < h) ? iy + 1 : h - 1;
        fp.addr[0] = pixel_addr(iy, ix, w);
        fp.addr[1] = pixel_addr(iy2, ix, w);
        fp.addr[2] = pixel_addr(iy, ix2, w);
        fp.addr[3] = pixel_addr(iy2, ix2, w);
        return fp;
    endfunction

    function automatic value_set_t bilerp_at(logic signed [COORD_W-1:0] sx,
                                             logic signed [COORD_W-1:0] sy);
        footprint_t fp;
        int unsigned n, s, c00, c01, c10, c11, a, b, t;
        value_set_t v;
        fp = footprint(sx, sy);
        n = (cfg_comps == 0) ? 1 : ((cfg_comps > CHANNELS) ? CHANNELS : cfg_comps);
        s = 1 << FRACTION_BITS_DEF;
        v = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (k < n)
            begin
                c00 = pixel_mem[fp.addr[0]][CHAN_W*k +: CHAN_W];
                c01 = pixel_mem[fp.addr[1]][CHAN_W*k +: CHAN_W];
                c10 = pixel_mem[fp.addr[2]][CHAN_W*k +: CHAN_W];
                c11 = pixel_mem[fp.addr[3]][CHAN_W*k +: CHAN_W];
                a = c00 * (s - fp.fy) + c01 * fp.fy;
                b = c10 * (s - fp.fy) + c11 * fp.fy;
                t = a * (s - fp.fx) + b * fp.fx;
                v[k] = VALUE_W'(t >> (2 * FRACTION_BITS_DEF - 8));
            end
        end
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim);
        int unsigned far_edge;
        far_edge = (dim - 1) << FRACTION_BITS_DEF;
        case ($urandom_range(9))
            0: return COORD_W'($urandom);
            1: return COORD_W'(0 - $urandom_range(1, 3000));
            2: return COORD_W'(far_edge + $urandom_range(0, 700));
            3: return COORD_W'(far_edge);
            default: return COORD_W'($urandom_range(0, far_edge));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [PIXEL_W-1:0] data,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic known, input value_set_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        operation   <= op;
        pixel_index <= idx;
        pixel_data  <= data;
        sample_x    <= sx;
        sample_y    <= sy;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (op == OP_SAMPLE)
        begin
            predicted_values.push_back(known ? want : bilerp_at(sx, sy));
            items_sent++;
        end
        else if (idx < image_area())
        begin
            pixel_mem[idx] = data;
            pixel_written[idx] = 1'b1;
            items_sent++;
        end
    endtask

    // fill any unwritten neighbor first so the sample never reads a stale entry
    task automatic send_sample(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        footprint_t fp;
        fp = footprint(sx, sy);
        for (int k = 0; k < CORNERS; k++)
        begin
            if (!pixel_written[fp.addr[k]])
                send_item(OP_WRITE, fp.addr[k], $urandom, COORD_W'($urandom),
                          COORD_W'($urandom), 1'b0, '0);
        end
        send_item(OP_SAMPLE, INDEX_W'($urandom), $urandom, sx, sy, 1'b0, '0);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (predicted_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(input logic [1:0] sel, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] keep;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        keep = '0;
        case (sel)
            REG_WIDTH:
            begin
                cfg_width = val[CFG_DIM_W-1:0];
                keep = APB_DATA_W'(cfg_width);
            end
            REG_HEIGHT:
            begin
                cfg_height = val[CFG_DIM_W-1:0];
                keep = APB_DATA_W'(cfg_height);
            end
            REG_COMPS:
            begin
                cfg_comps = val[CFG_COMP_W-1:0];
                keep = APB_DATA_W'(cfg_comps);
            end
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (sel != REG_SPARE && prdata !== keep)
        begin
            mismatches++;
            $display("%0t: register %0d read back: expected %h, actual %h",
                     $time, sel, keep, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [APB_DATA_W-1:0] wv, input logic [APB_DATA_W-1:0] hv,
                             input logic [APB_DATA_W-1:0] nv, input int idle, input int stall,
                             input bit squeeze);
        int unsigned goal, area, r;
        settle();
        program_reg(REG_WIDTH, wv);
        program_reg(REG_HEIGHT, hv);
        program_reg(REG_COMPS, nv);
        idle_pct = idle;
        stall_pct <= stall;
        if (squeeze)
            hold_asked <= hold_asked + 1;
        area = image_area();
        if (area > STORE_DEPTH_DEF)
            area = STORE_DEPTH_DEF;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            r = $urandom_range(19);
            if (r < 2)
                send_item(OP_WRITE, INDEX_W'($urandom), $urandom, COORD_W'($urandom),
                          COORD_W'($urandom), 1'b0, '0);
            else if (r < 8)
                send_item(OP_WRITE, INDEX_W'($urandom_range(0, area - 1)), $urandom,
                          COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
            else
                send_sample(pick_coord(eff_dim(cfg_width)), pick_coord(eff_dim(cfg_height)));
        end
    endtask

    always @(posedge clk)
    begin
        value_set_t got, want;
        if (rst_n && result_valid && result_ready)
        begin
            got = {value_c3, value_c2, value_c1, value_c0};
            if (predicted_values.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat: expected none, actual %h", $time, got);
            end
            else
            begin
                want = predicted_values.pop_front();
                for (int k = 0; k < CHANNELS; k++)
                begin
                    if (got[k] !== want[k])
                    begin
                        mismatches++;
                        $display("%0t: value_c%0d: expected %h, actual %h",
                                 $time, k, want[k], got[k]);
                    end
                end
            end
        end
        if (hold_asked != hold_seen)
        begin
            hold_seen    <= hold_asked;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #(TIMEOUT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int row = 0; row < PLAN_LEN; row++)
        begin
            if (PLAN[row].kind == ROW_CFG)
            begin
                settle();
                program_reg(PLAN[row].idx[1:0], PLAN[row].data);
            end
            else
                send_item(PLAN[row].op, PLAN[row].idx, PLAN[row].data, PLAN[row].sx,
                          PLAN[row].sy, PLAN[row].known, PLAN[row].want);
        end
        run_phase(32'hFFFF_F808, 8, 4, 0, 0, 1'b0);
        run_phase(1, 1024, 2, 70, 0, 1'b0);
        run_phase(1024, 1, 3, 0, 70, 1'b0);
        run_phase(1024, 1024, 4, 10, 10, 1'b0);
        run_phase(3, 5, 1, 0, 0, 1'b1);
        run_phase(2047, 0, 6, 0, 70, 1'b0);
        run_phase(37, 29, 0, 70, 0, 1'b0);
        run_phase(256, 256, 7, 10, 10, 1'b0);
        run_phase($urandom_range(1, 80), $urandom_range(1, 80), $urandom_range(1, 4),
                  0, 0, 1'b0);
        settle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
src/bps_pkg.sv
src/bps_config.sv
src/bps_addr.sv
src/bps_store.sv
src/bps_blend.sv
src/bilinear_pixel_sampler.sv
test/bilinear_pixel_sampler_test.sv
